[design/aht_pkg.sv]
package aht_pkg;

   localparam int SLOTS_DEF   = 64;
   localparam int MAX_LEN_DEF = 256;
   localparam int HANDLE_BASE = 32'hDEAD + 32'hBEEF;
   localparam int HANDLE_W    = 18;
   localparam int LEN_W       = 8;
   localparam int WORD_W      = 32;
   localparam int QDEPTH      = 2;

   typedef enum logic [2:0] {
      OP_CREATE   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_SET      = 3'd2,
      OP_GET      = 3'd3,
      OP_LENGTH   = 3'd4,
      OP_IS_VALID = 3'd5,
      OP_RESIZE   = 3'd6,
      OP_CLONE    = 3'd7
   } aht_op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_LEN    = 3'd1,
      ST_FULL       = 3'd2,
      ST_BAD_HANDLE = 3'd3,
      ST_BAD_INDEX  = 3'd4
   } aht_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DISPATCH,
      BK_SCAN,
      BK_FILL,
      BK_COPY_RD,
      BK_COPY_WR,
      BK_GET,
      BK_COMMIT
   } aht_state_type;

   // classified request as it travels from front to back
   typedef struct packed {
      aht_op_type           op;
      logic [HANDLE_W-1:0]  handle;
      logic [HANDLE_W-1:0]  diff;
      logic                 in_range;
      logic [LEN_W-1:0]     elem_index;
      logic [LEN_W-1:0]     req_length;
      logic                 len_ok;
      logic [WORD_W-1:0]    elem_value;
   } aht_cmd_type;

endpackage

[design/array_handle_table_allocator_core.sv]
// channel   | dir | signals              | contents
// req_      | in  | tvalid/tready/tdata  | tuser: action; tdata: handle, index, length, value
//           |     | tuser                |
// rsp_      | out | tvalid/tready/tdata  | tuser: status; tdata: data, handle, length, valid
//           |     | tuser                |
// A request is popped when no response waits and its slot length is read; delete, set,
// length and is_valid answer from dispatch, get after an element memory read. Create
// and clone scan one slot per cycle for a free one, then create zero-fills one word a
// cycle and clone copies each word by a read and a write state; resize zero-fills the
// grown tail one word a cycle. A 2-entry queue lets the front accept while the back
// works or a response waits. Reset clears live bits and control state, not memories.
module array_handle_table_allocator_core #(
   parameter int SLOTS   = aht_pkg::SLOTS_DEF,
   parameter int MAX_LEN = aht_pkg::MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // handle[17:0] elem_index[25:18] req_length[33:26]
                                    // elem_value[65:34], zero pad
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // data_out[31:0] handle_out[49:32] length_out[57:50]
                                    // is_valid[58], zero pad
   output logic [2:0]  rsp_tuser    // status[2:0]
);
   import aht_pkg::*;

   aht_cmd_type push_cmd, head_cmd;
   logic        q_push, q_pop, q_full, q_empty;

   aht_front #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   aht_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   aht_back #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[design/aht_front.sv]
module aht_front #(
   parameter int SLOTS   = aht_pkg::SLOTS_DEF,
   parameter int MAX_LEN = aht_pkg::MAX_LEN_DEF
) (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [71:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  logic                 q_full,
   output logic                 q_push,
   output aht_pkg::aht_cmd_type q_cmd
);
   import aht_pkg::*;

   logic [HANDLE_W-1:0] handle;
   logic [LEN_W-1:0]    req_length;
   logic                above_base;

   assign handle     = req_tdata[17:0];
   assign req_length = req_tdata[33:26];
   assign above_base = 32'(handle) >= HANDLE_BASE;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd            = '0;
      q_cmd.op         = aht_op_type'(req_tuser);
      q_cmd.handle     = handle;
      q_cmd.diff       = HANDLE_W'(32'(handle) - HANDLE_BASE);
      q_cmd.in_range   = above_base && (32'(q_cmd.diff) < SLOTS);
      q_cmd.elem_index = req_tdata[25:18];
      q_cmd.req_length = req_length;
      q_cmd.len_ok     = (req_length != '0) && (32'(req_length) < MAX_LEN);
      q_cmd.elem_value = req_tdata[65:34];
   end

endmodule

[design/aht_queue.sv]
module aht_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  aht_pkg::aht_cmd_type push_cmd,
   input  logic                 pop,
   output aht_pkg::aht_cmd_type head_cmd,
   output logic                 full,
   output logic                 empty
);
   import aht_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);

   aht_cmd_type        entry_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign full     = count_ff == (PTR_W+1)'(QDEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/aht_back.sv]
module aht_back #(
   parameter int SLOTS   = aht_pkg::SLOTS_DEF,
   parameter int MAX_LEN = aht_pkg::MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  aht_pkg::aht_cmd_type q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser
);
   import aht_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(MAX_LEN);
   localparam int AW     = SLOT_W + IDX_W;

   // element words and slot lengths, one write and one registered read each
   logic [WORD_W-1:0] elem_mem [2**AW];
   logic [LEN_W-1:0]  len_mem  [SLOTS];

   aht_state_type     state_ff, state_in;
   aht_cmd_type       cmd_ff, cmd_in;
   logic [SLOTS-1:0]  live_ff, live_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [SLOT_W-1:0] dst_ff, dst_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  end_ff, end_in;
   logic [LEN_W-1:0]  len_rd_ff;
   logic [WORD_W-1:0] elem_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   aht_status_type      status_ff, status_in;
   logic [WORD_W-1:0]   data_ff, data_in;
   logic [HANDLE_W-1:0] hout_ff, hout_in;
   logic [LEN_W-1:0]    lout_ff, lout_in;
   logic                valid_ff, valid_in;

   logic [SLOT_W-1:0] len_raddr;
   logic              len_we;
   logic [AW-1:0]     elem_raddr, elem_waddr;
   logic              elem_we;
   logic [WORD_W-1:0] elem_wdata;
   logic [SLOT_W-1:0] slot;
   logic              live;

   assign slot = cmd_ff.diff[SLOT_W-1:0];
   assign live = cmd_ff.in_range && live_ff[slot];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      live_in      = live_ff;
      scan_in      = scan_ff;
      dst_in       = dst_ff;
      j_in         = j_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      data_in      = data_ff;
      hout_in      = hout_ff;
      lout_in      = lout_ff;
      valid_in     = valid_ff;
      q_pop        = 1'b0;
      len_raddr    = q_head.diff[SLOT_W-1:0];
      len_we       = 1'b0;
      elem_raddr   = {slot, IDX_W'(cmd_ff.elem_index)};
      elem_we      = 1'b0;
      elem_waddr   = {dst_ff, IDX_W'(j_ff)};
      elem_wdata   = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               state_in = BK_DISPATCH;
            end
         end

         BK_DISPATCH: begin
            // default response: ok with all fields clear
            rsp_valid_in = 1'b1;
            status_in    = ST_OK;
            data_in      = '0;
            hout_in      = '0;
            lout_in      = '0;
            valid_in     = 1'b0;
            state_in     = BK_IDLE;
            dst_in       = slot;
            scan_in      = '0;
            unique case (cmd_ff.op) inside
               OP_CREATE: begin
                  if (!cmd_ff.len_ok) begin
                     status_in = ST_BAD_LEN;
                  end else begin
                     rsp_valid_in = 1'b0;
                     j_in         = '0;
                     end_in       = cmd_ff.req_length;
                     state_in     = BK_SCAN;
                  end
               end
               OP_DELETE: begin
                  if (!live) begin
                     status_in = ST_BAD_HANDLE;
                  end else begin
                     live_in[slot] = 1'b0;
                  end
               end
               OP_SET, OP_GET: begin
                  if (!live) begin
                     status_in = ST_BAD_HANDLE;
                  end else if (cmd_ff.elem_index >= len_rd_ff) begin
                     status_in = ST_BAD_INDEX;
                  end else if (cmd_ff.op == OP_SET) begin
                     elem_we    = 1'b1;
                     elem_waddr = {slot, IDX_W'(cmd_ff.elem_index)};
                     elem_wdata = cmd_ff.elem_value;
                     data_in    = cmd_ff.elem_value;
                  end else begin
                     rsp_valid_in = 1'b0;
                     state_in     = BK_GET;
                  end
               end
               OP_LENGTH: begin
                  if (!live) begin
                     status_in = ST_BAD_HANDLE;
                  end else begin
                     lout_in = len_rd_ff;
                  end
               end
               OP_IS_VALID: begin
                  valid_in = live;
               end
               OP_RESIZE: begin
                  if (!live) begin
                     status_in = ST_BAD_HANDLE;
                  end else if (!cmd_ff.len_ok) begin
                     status_in = ST_BAD_LEN;
                  end else begin
                     rsp_valid_in = 1'b0;
                     j_in         = len_rd_ff;
                     end_in       = cmd_ff.req_length;
                     state_in     = (len_rd_ff < cmd_ff.req_length) ? BK_FILL : BK_COMMIT;
                  end
               end
               default: begin
                  if (!live) begin
                     status_in = ST_BAD_HANDLE;
                  end else begin
                     rsp_valid_in = 1'b0;
                     j_in         = '0;
                     end_in       = len_rd_ff;
                     state_in     = BK_SCAN;
                  end
               end
            endcase
         end

         BK_SCAN: begin
            // one slot per cycle, lowest first
            if (!live_ff[scan_ff]) begin
               dst_in   = scan_ff;
               state_in = (cmd_ff.op == OP_CLONE) ? BK_COPY_RD : BK_FILL;
            end else if (scan_ff == SLOT_W'(SLOTS - 1)) begin
               rsp_valid_in = 1'b1;
               status_in    = ST_FULL;
               data_in      = '0;
               hout_in      = '0;
               lout_in      = '0;
               valid_in     = 1'b0;
               state_in     = BK_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         BK_FILL: begin
            elem_we    = 1'b1;
            elem_wdata = '0;
            j_in       = j_ff + 1'b1;
            if (j_ff == end_ff - 1'b1) begin
               state_in = BK_COMMIT;
            end
         end

         BK_COPY_RD: begin
            elem_raddr = {slot, IDX_W'(j_ff)};
            state_in   = BK_COPY_WR;
         end

         BK_COPY_WR: begin
            elem_we    = 1'b1;
            elem_wdata = elem_rd_ff;
            j_in       = j_ff + 1'b1;
            state_in   = (j_ff == end_ff - 1'b1) ? BK_COMMIT : BK_COPY_RD;
         end

         BK_GET: begin
            rsp_valid_in = 1'b1;
            data_in      = elem_rd_ff;
            state_in     = BK_IDLE;
         end

         BK_COMMIT: begin
            len_we        = 1'b1;
            live_in[dst_ff] = 1'b1;
            rsp_valid_in  = 1'b1;
            status_in     = ST_OK;
            data_in       = '0;
            hout_in       = HANDLE_W'(32'(dst_ff) + HANDLE_BASE);
            lout_in       = '0;
            valid_in      = 1'b0;
            state_in      = BK_IDLE;
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      scan_ff   <= scan_in;
      dst_ff    <= dst_in;
      j_ff      <= j_in;
      end_ff    <= end_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      hout_ff   <= hout_in;
      lout_ff   <= lout_in;
      valid_ff  <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[dst_ff] <= end_ff;
      end
      len_rd_ff <= len_mem[len_raddr];
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= elem_wdata;
      end
      elem_rd_ff <= elem_mem[elem_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'b0, valid_ff, lout_ff, hout_ff, data_ff};

endmodule

[sim/handle_table_checker.sv]
`timescale 1ns / 1ps

module handle_table_checker
   import aht_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          errors,
   output int          pending,
   output int          checked,
   output int          full_seen
);

   localparam int SLOTS   = SLOTS_DEF;
   localparam int MAX_LEN = MAX_LEN_DEF;

   typedef struct packed {
      aht_status_type      status;
      logic [WORD_W-1:0]   data;
      logic [HANDLE_W-1:0] hnd;
      logic [LEN_W-1:0]    len;
      logic                valid;
   } table_rsp_type;

   logic [LEN_W-1:0]  live_len [SLOTS];
   logic [WORD_W-1:0] words [SLOTS*MAX_LEN];
   table_rsp_type     expected_rsp_q [$];

   function automatic int slot_of(logic [HANDLE_W-1:0] h);
      int s;
      if (int'(h) < HANDLE_BASE) return -1;
      s = int'(h) - HANDLE_BASE;
      if (s >= SLOTS || live_len[s] == 0) return -1;
      return s;
   endfunction

   function automatic int lowest_free();
      for (int s = 0; s < SLOTS; s++)
         if (live_len[s] == 0) return s;
      return -1;
   endfunction

   function automatic table_rsp_type table_answer(aht_op_type op, logic [HANDLE_W-1:0] h,
                                                  logic [7:0] idx, logic [7:0] len,
                                                  logic [31:0] val);
      table_rsp_type r;
      int s, f;
      int len_good;
      r = '0;
      r.status = ST_OK;
      s = slot_of(h);
      len_good = (len >= 1) && (int'(len) < MAX_LEN);
      case (op)
         OP_CREATE: begin
            if (!len_good) r.status = ST_BAD_LEN;
            else begin
               f = lowest_free();
               if (f < 0) r.status = ST_FULL;
               else begin
                  for (int j = 0; j < len; j++) words[f*MAX_LEN+j] = '0;
                  live_len[f] = len;
                  r.hnd = HANDLE_W'(f + HANDLE_BASE);
               end
            end
         end
         OP_DELETE: begin
            if (s < 0) r.status = ST_BAD_HANDLE;
            else live_len[s] = '0;
         end
         OP_SET, OP_GET: begin
            if (s < 0) r.status = ST_BAD_HANDLE;
            else if (idx >= live_len[s]) r.status = ST_BAD_INDEX;
            else begin
               if (op == OP_SET) words[s*MAX_LEN+idx] = val;
               r.data = words[s*MAX_LEN+idx];
            end
         end
         OP_LENGTH: begin
            if (s < 0) r.status = ST_BAD_HANDLE;
            else r.len = live_len[s];
         end
         OP_IS_VALID: r.valid = (s >= 0);
         OP_RESIZE: begin
            if (s < 0) r.status = ST_BAD_HANDLE;
            else if (!len_good) r.status = ST_BAD_LEN;
            else begin
               for (int j = live_len[s]; j < len; j++) words[s*MAX_LEN+j] = '0;
               live_len[s] = len;
               r.hnd = h;
            end
         end
         default: begin
            if (s < 0) r.status = ST_BAD_HANDLE;
            else begin
               f = lowest_free();
               if (f < 0) r.status = ST_FULL;
               else begin
                  for (int j = 0; j < live_len[s]; j++)
                     words[f*MAX_LEN+j] = words[s*MAX_LEN+j];
                  live_len[f] = live_len[s];
                  r.hnd = HANDLE_W'(f + HANDLE_BASE);
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      table_rsp_type e;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) live_len[s] = '0;
         expected_rsp_q.delete();
         errors    = 0;
         checked   = 0;
         full_seen = 0;
         pending   = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(table_answer(aht_op_type'(req_tuser), req_tdata[17:0],
                                     req_tdata[25:18], req_tdata[33:26], req_tdata[65:34]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response status=%0d tdata=%h", rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               e = expected_rsp_q.pop_front();
               checked++;
               if (e.status == ST_FULL) full_seen++;
               if (rsp_tuser != e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[31:0] != e.data) begin
                  $error("data_out expected %h actual %h", e.data, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[49:32] != e.hnd) begin
                  $error("handle_out expected %0d actual %0d", e.hnd, rsp_tdata[49:32]);
                  errors++;
               end
               if (rsp_tdata[57:50] != e.len) begin
                  $error("length_out expected %0d actual %0d", e.len, rsp_tdata[57:50]);
                  errors++;
               end
               if (rsp_tdata[58] != e.valid) begin
                  $error("is_valid expected %0d actual %0d", e.valid, rsp_tdata[58]);
                  errors++;
               end
            end
         end
         pending = expected_rsp_q.size();
      end
   end

endmodule

[sim/array_handle_table_allocator_core_tb.sv]
`timescale 1ns / 1ps

module array_handle_table_allocator_core_tb;
   import aht_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int DRAIN_CYCLES = 900;
   localparam logic [17:0] HB  = 18'(HANDLE_BASE);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int errors, pending, checked, full_seen;
   int sent = 0;
   int cycles = 0;
   int hold_left = 0;
   bit hold_done = 0;

   always #5 clock = ~clock;

   array_handle_table_allocator_core dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   handle_table_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .errors, .pending, .checked, .full_seen
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("array_handle_table_allocator_core_tb: done, errors");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off, a quiet stretch with no stalls
   always @(negedge clock) begin
      if (!reset && !hold_done && sent == 120) begin
         hold_left = 400;
         hold_done = 1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (sent >= 500 && sent < 750) begin
         rsp_tready = 1'b1;
      end else begin
         rsp_tready = ($urandom_range(99) >= 9);
      end
   end

   task automatic send(aht_op_type op, logic [17:0] h, logic [7:0] idx, logic [7:0] len,
                       logic [31:0] val);
      if (!(sent >= 500 && sent < 750) && $urandom_range(99) < 9) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {6'b0, val, len, idx, h};
      // ready only moves at rising edges, so a falling-edge look decides the next edge
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [17:0] pick_handle();
      int r;
      r = $urandom_range(99);
      if (r < 60) return HB + 18'($urandom_range(0, 15));
      if (r < 85) return HB + 18'($urandom_range(0, 63));
      if (r < 90) return HB - 18'd1;
      if (r < 95) return HB + 18'd64;
      return 18'($urandom);
   endfunction

   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 8'($urandom_range(1, 8));
      if (r < 90) return 8'($urandom_range(0, 40));
      if (r < 95) return 8'd255;
      if (r < 98) return 8'($urandom);
      return 8'd0;
   endfunction

   function automatic aht_op_type pick_op(bit filling);
      int r;
      r = $urandom_range(99);
      if (r < (filling ? 30 : 8)) return OP_CREATE;
      if (r < 35) return filling ? OP_CLONE : OP_DELETE;
      if (r < 50) return filling ? OP_DELETE : OP_CLONE;
      if (r < 65) return OP_SET;
      if (r < 80) return OP_GET;
      if (r < 86) return OP_LENGTH;
      if (r < 92) return OP_IS_VALID;
      return OP_RESIZE;
   endfunction

   initial begin
      aht_op_type op;
      logic [7:0] idx;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send(OP_CREATE, '0, '0, 8'd1, '0);
      send(OP_CREATE, '0, '0, 8'd255, '0);
      send(OP_CREATE, '0, '0, 8'd0, '0);
      send(OP_SET, HB, 8'd0, '0, 32'hFFFF_FFFF);
      send(OP_SET, HB, 8'd1, '0, 32'h1234_5678);
      send(OP_GET, HB, 8'd0, '0, '0);
      send(OP_SET, HB + 18'd1, 8'd254, 8'hFF, 32'hA5A5_5A5A);
      send(OP_GET, HB + 18'd1, 8'd255, '0, '0);
      send(OP_LENGTH, HB + 18'd1, '0, '0, '0);
      send(OP_IS_VALID, HB, '0, '0, '0);
      send(OP_IS_VALID, HB - 18'd1, '0, '0, '0);
      send(OP_IS_VALID, HB + 18'd64, '0, '0, '0);
      send(OP_IS_VALID, 18'h3FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send(OP_DELETE, HB, '0, '0, '0);
      send(OP_DELETE, HB, '0, '0, '0);
      send(OP_GET, HB, 8'd0, '0, '0);
      send(OP_CREATE, '0, '0, 8'd3, '0);
      send(OP_RESIZE, HB, '0, 8'd10, '0);
      send(OP_GET, HB, 8'd9, '0, '0);
      send(OP_RESIZE, HB, '0, 8'd2, '0);
      send(OP_RESIZE, HB, '0, 8'd0, '0);
      send(OP_RESIZE, HB + 18'd40, '0, 8'd0, '0);
      send(OP_CLONE, HB + 18'd1, '0, '0, '0);
      send(OP_GET, HB + 18'd2, 8'd254, '0, '0);
      send(OP_CLONE, 18'd0, '0, '0, '0);

      // alternate fill-up and drain-down phases so the pool runs full
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op  = pick_op((i / 200) % 2 == 0);
         idx = ($urandom_range(99) < 75) ? 8'($urandom_range(0, 7)) : 8'($urandom);
         send(op, pick_handle(), idx, pick_length(), $urandom);
      end
      req_tvalid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d requests, checked %0d responses, %0d pool-full answers",
               sent, checked, full_seen);
      $display("covered every action, handle and index errors, grow, shrink and clone");
      if (errors == 0)
         $display("array_handle_table_allocator_core_tb: done, clean");
      else
         $display("array_handle_table_allocator_core_tb: done, errors");
      $finish;
   end

endmodule

[array_handle_table_allocator_core.f]
design/aht_pkg.sv
design/aht_front.sv
design/aht_queue.sv
design/aht_back.sv
design/array_handle_table_allocator_core.sv
sim/handle_table_checker.sv
sim/array_handle_table_allocator_core_tb.sv
